>>> design/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes for the double-ended queue: word formats, mode and
// status codes, and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

    // fixed field widths of the input and result words
    localparam int MODE_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 7;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DELETE     = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    // input word
    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [VALUE_W-1:0] value;
    } t_in_word;

    // result word
    typedef struct packed {
        logic signed [VALUE_W-1:0] popped;
        logic [STATUS_W-1:0]       status;
        logic [OCC_W-1:0]          occupancy;
    } t_out_word;

    // controller to datapath
    typedef struct packed {
        logic accept;      // latch the input word and issue the early read
        logic finish;      // execute push, pop or no-op and load the result
        logic del_start;   // clear the delete walk counters
        logic del_step;    // advance the delete walk by one entry
        logic del_finish;  // commit the compacted count and load the result
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_delete;   // latched word is a delete
        logic del_done;    // delete walk has drained
        logic out_free;    // result register can take a word this cycle
    } t_dp_stat;

endpackage

`default_nettype wire

>>> design/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, held when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer for the queue: accepts one word, executes it, and steps the
// delete walk until the datapath reports it drained.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  deq_pkg::t_dp_stat i_stat,
    output deq_pkg::t_dp_cmd  o_cmd
);

    import deq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DEL  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.is_delete) begin
                    o_cmd.del_start = 1'b1;
                    n_state         = S_DEL;
                end else if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_DEL: begin
                o_cmd.del_step = 1'b1;
                if (i_stat.del_done && i_stat.out_free) begin
                    o_cmd.del_finish = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> design/deq_dp.sv
// ----------------------------------------------------------------------------
// deq_dp
// Queue datapath: circular entry store, head and count registers, the
// delete compaction walk and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_dp #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  deq_pkg::t_dp_cmd   i_cmd,
    output deq_pkg::t_dp_stat  o_stat,
    input  deq_pkg::t_in_word  i_in_word,
    output deq_pkg::t_out_word o_out_word,
    output logic               o_out_valid,
    input  logic               i_out_ready
);

    import deq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    // position of an entry counted from the head, wrapped into the store
    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] head,
                                             input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(off);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    logic [AW-1:0]         r_head,  n_head;
    logic [CW-1:0]         r_count, n_count;
    logic [MODE_W-1:0]     r_mode,  n_mode;
    logic [DATA_WIDTH-1:0] r_word,  n_word;
    logic [CW-1:0]         r_rd,    n_rd;
    logic [CW-1:0]         r_wr,    n_wr;
    logic                  r_pend,  n_pend;
    t_out_word             r_out,   n_out;
    logic                  r_out_valid, n_out_valid;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic                  is_full;
    logic                  is_empty;
    logic [CW-1:0]         last_off;
    logic [AW-1:0]         head_m1;
    logic                  issue;
    logic                  keep;

    assign is_full  = (r_count == CW'(DEPTH));
    assign is_empty = (r_count == '0);
    assign last_off = is_empty ? '0 : r_count - 1'b1;
    assign head_m1  = (r_head == '0) ? AW'(DEPTH - 1) : r_head - 1'b1;
    assign issue    = (r_rd < r_count);
    assign keep     = r_pend && (ram_rdata != r_word);

    // next-state logic for all operations
    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_mode      = r_mode;
        n_word      = r_word;
        n_rd        = r_rd;
        n_wr        = r_wr;
        n_pend      = r_pend;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        ram_we      = 1'b0;
        ram_waddr   = f_slot(r_head, r_count);
        ram_wdata   = r_word;
        ram_re      = 1'b0;
        ram_raddr   = f_slot(r_head, '0);

        // latch the word and read the entry a pop would take
        if (i_cmd.accept) begin
            n_mode = i_in_word.mode;
            n_word = DATA_WIDTH'($unsigned(i_in_word.value));
            ram_re = 1'b1;
            if (i_in_word.mode == MODE_POP_BACK) begin
                ram_raddr = f_slot(r_head, last_off);
            end
        end

        // push, pop or ignored mode
        if (i_cmd.finish) begin
            n_out_valid  = 1'b1;
            n_out.popped = '1;
            n_out.status = STAT_OK;
            case (r_mode) inside
                MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
                    if (is_full) begin
                        n_out.status = STAT_FULL;
                    end else begin
                        ram_we  = 1'b1;
                        n_count = r_count + 1'b1;
                        if (r_mode == MODE_PUSH_FRONT) begin
                            ram_waddr = head_m1;
                            n_head    = head_m1;
                        end
                    end
                end
                MODE_POP_BACK, MODE_POP_FRONT: begin
                    if (is_empty) begin
                        n_out.status = STAT_EMPTY;
                    end else begin
                        n_out.popped = VALUE_W'($signed(ram_rdata));
                        n_count      = r_count - 1'b1;
                        if (r_mode == MODE_POP_FRONT) begin
                            n_head = f_slot(r_head, CW'(1));
                        end
                    end
                end
                default: begin
                end
            endcase
            n_out.occupancy = OCC_W'(n_count);
        end

        // delete walk setup
        if (i_cmd.del_start) begin
            n_rd   = '0;
            n_wr   = '0;
            n_pend = 1'b0;
        end

        // delete walk: read ahead one entry, write back the kept ones
        if (i_cmd.del_step) begin
            n_pend = issue;
            if (issue) begin
                ram_re    = 1'b1;
                ram_raddr = f_slot(r_head, r_rd);
                n_rd      = r_rd + 1'b1;
            end
            if (keep) begin
                ram_we    = 1'b1;
                ram_waddr = f_slot(r_head, r_wr);
                ram_wdata = ram_rdata;
                n_wr      = r_wr + 1'b1;
            end
        end

        // delete result
        if (i_cmd.del_finish) begin
            n_count         = r_wr;
            n_out_valid     = 1'b1;
            n_out.popped    = '1;
            n_out.status    = STAT_OK;
            n_out.occupancy = OCC_W'(r_wr);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_word <= n_word;
        r_rd   <= n_rd;
        r_wr   <= n_wr;
        r_out  <= n_out;
    end

    // entry store
    deq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // status to the controller
    assign o_stat.is_delete = (r_mode == MODE_DELETE);
    assign o_stat.del_done  = (r_rd == r_count) && !r_pend;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_word  = r_out;
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

>>> design/deque_with_value_delete.sv
// ----------------------------------------------------------------------------
// deque_with_value_delete: bounded double-ended queue with delete-by-value
// Push, pop and unused modes pass from accept through the execute state to the result register.
// Delete walks the held entries, one entry per cycle through the RAM port.
// One word in flight; synchronous reset empties the queue, store contents undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module deque_with_value_delete #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  deq_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output deq_pkg::t_out_word o_out_word
);

    import deq_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencer
    deq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // store, pointers and result register
    deq_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_word   (i_in_word),
        .o_out_word  (o_out_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready)
    );

`ifndef ASSERT_OFF
    // one word at a time: no accept right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("accepted a word while another was in flight");

    // a refused push or pop returns -1
    a_fail_popped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status != STAT_OK) |-> (o_out_word.popped == '1))
        else $error("failed operation returned a value");

    // an empty pop reports an empty queue
    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status == STAT_EMPTY) |->
        (o_out_word.occupancy == '0))
        else $error("empty status with entries held");

    // a dropped push reports a full queue
    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status == STAT_FULL) |->
        (o_out_word.occupancy == OCC_W'(DEPTH)))
        else $error("full status without a full queue");
`endif

endmodule

`default_nettype wire

>>> dv/tb_deque_with_value_delete.sv
// ----------------------------------------------------------------------------
// tb_deque_with_value_delete
// Self-checking bench for the double-ended queue with delete-by-value. A short
// table of directed words covers empty pops, extremes, unused modes and delete
// with and without matches. A fill burst and biased random traffic follow.
// Every result word is checked against its table entry or a cycle-free model of the queue.
// ----------------------------------------------------------------------------

module tb_deque_with_value_delete;
    timeunit 1ns;
    timeprecision 1ps;

    import deq_pkg::*;

    localparam int DEPTH       = 64;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int N_RANDOM    = 1380;
    localparam int N_ROWS      = 23;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER  = 250;
    localparam int STEADY_LO   = 600;
    localparam int STEADY_HI   = 850;

    // mode codes the block ignores
    localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_word  in_word   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_word out_word;

    // one directed row; typed rows carry their result, the rest use the model
    typedef struct {
        logic [MODE_W-1:0]   mode;
        logic [VALUE_W-1:0]  value;
        bit                  typed;
        logic [VALUE_W-1:0]  popped;
        logic [STATUS_W-1:0] status;
        logic [OCC_W-1:0]    occ;
    } row_t;

    row_t dir_rows [N_ROWS];

    // queue model state
    logic [VALUE_W-1:0] dq_store [DEPTH];
    logic [IDX_W-1:0]   dq_head  = '0;
    logic [OCC_W-1:0]   dq_count = '0;

    t_out_word expected_q [$];
    int        err_cnt   = 0;
    int        n_results = 0;
    bit        steady    = 1'b0;

    deque_with_value_delete #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (VALUE_W)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    // 2 ns clock
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [IDX_W-1:0] ring_slot(input logic [OCC_W-1:0] offset);
        return dq_head + offset[IDX_W-1:0];
    endfunction

    // apply one word to the queue model and return the result word it gives
    function automatic t_out_word deque_step(input t_in_word w);
        t_out_word          r;
        logic [OCC_W-1:0]   kept;
        logic [VALUE_W-1:0] e;
        r.popped = '1;
        r.status = STAT_OK;
        case (w.mode)
            MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
                if (dq_count == DEPTH) begin
                    r.status = STAT_FULL;
                end else if (w.mode == MODE_PUSH_BACK) begin
                    dq_store[ring_slot(dq_count)] = w.value;
                    dq_count++;
                end else begin
                    dq_head = dq_head - 1'b1;
                    dq_store[dq_head] = w.value;
                    dq_count++;
                end
            end
            MODE_POP_BACK, MODE_POP_FRONT: begin
                if (dq_count == 0) begin
                    r.status = STAT_EMPTY;
                end else if (w.mode == MODE_POP_BACK) begin
                    dq_count--;
                    r.popped = dq_store[ring_slot(dq_count)];
                end else begin
                    r.popped = dq_store[dq_head];
                    dq_head = dq_head + 1'b1;
                    dq_count--;
                end
            end
            MODE_DELETE: begin
                // compact in place, keeping the order of survivors
                kept = '0;
                for (int rd = 0; rd < dq_count; rd++) begin
                    e = dq_store[ring_slot(OCC_W'(rd))];
                    if (e != w.value) begin
                        dq_store[ring_slot(kept)] = e;
                        kept++;
                    end
                end
                dq_count = kept;
            end
            default: ;
        endcase
        r.occupancy = dq_count;
        return r;
    endfunction

    // hold the word until accepted, then run it through the model
    task automatic drive_word(input t_in_word w, output t_out_word pred);
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!in_ready);
        pred = deque_step(w);
    endtask

    // random sender idle cycles between words
    task automatic sender_gap();
        if (!steady && $urandom_range(99) < 38) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < 38);
        end
    endtask

    // mode mix for one traffic segment: 0 push-heavy, 1 pop-heavy, 2 balanced
    function automatic logic [MODE_W-1:0] pick_mode(input int bias);
        int r;
        int push_pct;
        r = $urandom_range(99);
        push_pct = (bias == 0) ? 60 : (bias == 1) ? 25 : 42;
        if (r < 2)
            return MODE_W'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO));
        if (r < 10)
            return MODE_DELETE;
        if (r < 10 + push_pct)
            return $urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
        return $urandom_range(1) ? MODE_POP_FRONT : MODE_POP_BACK;
    endfunction

    // word content: small pool for duplicates, held entries for deletes
    function automatic logic [VALUE_W-1:0] pick_value(input logic [MODE_W-1:0] mode);
        int r;
        r = $urandom_range(99);
        if (mode == MODE_DELETE && dq_count != 0 && r < 70)
            return dq_store[ring_slot(OCC_W'($urandom_range(dq_count - 1)))];
        if (r < 35)
            return VALUE_W'($urandom_range(7));
        if (r < 40)
            return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        return $urandom;
    endfunction

    // stimulus
    initial begin : stimulus
        t_in_word  w;
        t_out_word pred;
        t_out_word typed_res;
        int        bias;
        dir_rows = '{
            '{MODE_POP_BACK,   32'h0000_0000, 1, 32'hFFFF_FFFF, STAT_EMPTY, 7'd0},
            '{MODE_POP_FRONT,  32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, STAT_EMPTY, 7'd0},
            '{MODE_DELETE,     32'h0000_0000, 1, 32'hFFFF_FFFF, STAT_OK,    7'd0},
            '{MODE_UNUSED_LO,  32'h1234_5678, 1, 32'hFFFF_FFFF, STAT_OK,    7'd0},
            '{MODE_UNUSED_LO + 3'd1, 32'hAAAA_5555, 1, 32'hFFFF_FFFF, STAT_OK, 7'd0},
            '{MODE_UNUSED_HI,  32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, STAT_OK,    7'd0},
            '{MODE_PUSH_BACK,  32'h7FFF_FFFF, 1, 32'hFFFF_FFFF, STAT_OK,    7'd1},
            '{MODE_PUSH_FRONT, 32'h8000_0000, 1, 32'hFFFF_FFFF, STAT_OK,    7'd2},
            '{MODE_POP_FRONT,  32'h0000_0000, 1, 32'h8000_0000, STAT_OK,    7'd1},
            '{MODE_POP_BACK,   32'h0000_0000, 1, 32'h7FFF_FFFF, STAT_OK,    7'd0},
            '{MODE_PUSH_BACK,  32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, STAT_OK,    7'd1},
            '{MODE_UNUSED_HI,  32'h0000_0005, 0, '0, '0, '0},
            '{MODE_PUSH_FRONT, 32'h0000_0005, 0, '0, '0, '0},
            '{MODE_PUSH_BACK,  32'h0000_0005, 0, '0, '0, '0},
            '{MODE_PUSH_BACK,  32'h0000_0009, 0, '0, '0, '0},
            '{MODE_PUSH_FRONT, 32'h0000_0005, 0, '0, '0, '0},
            '{MODE_DELETE,     32'h0000_0005, 0, '0, '0, '0},
            '{MODE_DELETE,     32'h0000_0003, 0, '0, '0, '0},
            '{MODE_POP_FRONT,  32'h0000_0000, 0, '0, '0, '0},
            '{MODE_POP_BACK,   32'h0000_0000, 0, '0, '0, '0},
            '{MODE_POP_BACK,   32'h0000_0000, 1, 32'hFFFF_FFFF, STAT_EMPTY, 7'd0},
            '{MODE_PUSH_BACK,  32'h0000_0000, 1, 32'hFFFF_FFFF, STAT_OK,    7'd1},
            '{MODE_DELETE,     32'h0000_0000, 1, 32'hFFFF_FFFF, STAT_OK,    7'd0}
        };

        // reset
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (dir_rows[i]) begin
            w.mode  = dir_rows[i].mode;
            w.value = dir_rows[i].value;
            drive_word(w, pred);
            if (dir_rows[i].typed) begin
                typed_res.popped    = dir_rows[i].popped;
                typed_res.status    = dir_rows[i].status;
                typed_res.occupancy = dir_rows[i].occ;
                expected_q.push_back(typed_res);
            end else begin
                expected_q.push_back(pred);
            end
            sender_gap();
        end

        // fill from both ends until pushes are dropped
        for (int k = 0; k < DEPTH + 2; k++) begin
            w.mode  = k[0] ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
            w.value = $urandom;
            drive_word(w, pred);
            expected_q.push_back(pred);
            sender_gap();
        end

        // biased random traffic in segments
        bias = 0;
        for (int k = 0; k < N_RANDOM; k++) begin
            if (k % 40 == 0)
                bias = $urandom_range(2);
            steady = (k >= STEADY_LO && k < STEADY_HI);
            w.mode  = pick_mode(bias);
            w.value = pick_value(w.mode);
            drive_word(w, pred);
            expected_q.push_back(pred);
            sender_gap();
        end
        in_valid <= 1'b0;

        // drain and settle
        while (expected_q.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // result side ready, with one long hold-off while words keep coming
    initial begin : receiver
        bit held;
        held = 1'b0;
        forever begin
            @(posedge clk);
            if (!held && n_results >= HOLD_AFTER) begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= steady || ($urandom_range(99) >= 38);
        end
    end

    // compare each result word with the oldest expectation
    always @(posedge clk) begin : result_check
        t_out_word want;
        if (rst_n && out_valid && out_ready) begin
            n_results++;
            if (expected_q.size() == 0) begin
                $error("result word with nothing expected: %h", out_word);
                err_cnt++;
            end else begin
                want = expected_q.pop_front();
                if (out_word.popped !== want.popped) begin
                    $error("popped: expected %0d, got %0d", want.popped, out_word.popped);
                    err_cnt++;
                end
                if (out_word.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, out_word.status);
                    err_cnt++;
                end
                if (out_word.occupancy !== want.occupancy) begin
                    $error("occupancy: expected %0d, got %0d",
                           want.occupancy, out_word.occupancy);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk) begin : watchdog
        int stall_cycles;
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

endmodule

>>> deque_with_value_delete.f
design/deq_pkg.sv
design/deq_ram.sv
design/deq_ctrl.sv
design/deq_dp.sv
design/deque_with_value_delete.sv
dv/tb_deque_with_value_delete.sv
